/* hdl/knockout_tournament_rounds_assert.svh */
// Assertion macros shared by the knockout tournament checker.
`ifndef KNOCKOUT_TOURNAMENT_ROUNDS_ASSERT_SVH
`define KNOCKOUT_TOURNAMENT_ROUNDS_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define KOTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define KOTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/kotr_pkg.sv */
// Shared constants and types for the knockout tournament block.
package kotr_pkg;

  localparam int LOG_MAX  = 16;
  localparam int LVL_W    = $clog2(LOG_MAX + 1);
  localparam int ADDR_W   = $clog2(LOG_MAX);
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 16;
  localparam int ROUND_W  = 5;
  localparam int CFG_W    = 5;
  localparam int OUT_W    = ((INDEX_W + ROUND_W + 7) / 8) * 8;
  localparam int ENTRY_W  = VALUE_W + INDEX_W;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [INDEX_W-1:0]        index_t;

  typedef struct packed {
    value_t value;
    index_t index;
  } entry_t;

endpackage

/* hdl/knockout_tournament_rounds.sv */
// Each item is taken in IDLE, plays its matches in WALK, then parks or is reported
// as champion in FINISH; each match costs one read of the pending store. The block
// takes no new item until it is through with the last, and output stalls hold it.
// Reset: clears control state, the arrival count and the output valid flag, and sets
// log_size to 4. The pending store is not cleared; every entry is written before
// it is read.
module knockout_tournament_rounds (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write: log_size.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kotr_pkg::CFG_W-1:0]  cfg_data,
  // Input stream, tdata: player_value[31:0].
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [kotr_pkg::VALUE_W-1:0] s_axis_tdata,
  // Output stream, tdata: player_index[15:0], elimination_round[20:16], zeros above.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [kotr_pkg::OUT_W-1:0]  m_axis_tdata,
  // tlast: last_of_run, set on the final result caused by one input transfer.
  output logic                        m_axis_tlast
);
  import kotr_pkg::*;

  // IDLE takes a player, WALK resolves one match per cycle against the store while the output is not stalled,
  // FINISH either parks the surviving player or reports the champion.
  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t               state;
  logic [CFG_W-1:0]     log_size;
  logic [INDEX_W-1:0]   arrival_count;
  logic [INDEX_W-1:0]   pos;
  logic [INDEX_W-1:0]   pos_sh;
  logic [LVL_W-1:0]     level;
  value_t               cur_val;
  index_t               cur_idx;

  logic                 out_valid;
  index_t               out_index;
  logic [ROUND_W-1:0]   out_round;
  logic                 out_last;

  // Pending winners, one per level.
  entry_t               mem [LOG_MAX];
  entry_t               rd_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;

  logic [LVL_W-1:0]     n_eff;
  logic [INDEX_W-1:0]   mask;
  logic [INDEX_W-1:0]   pos_in;
  logic                 can_emit;
  logic                 cur_wins;
  logic [LVL_W-1:0]     nxt;
  logic                 walk_on;
  logic                 start_walk;
  logic                 in_take;
  logic                 emit;

  // A log_size above the store depth plays as the full depth.
  assign n_eff = (LVL_W'(log_size) > LVL_W'(LOG_MAX)) ? LVL_W'(LOG_MAX) : LVL_W'(log_size);

  always_comb begin
    for (int i = 0; i < INDEX_W; i++) begin
      mask[i] = (LVL_W'(i) < n_eff);
    end
  end

  assign pos_in     = arrival_count & mask;
  assign can_emit   = !out_valid || m_axis_tready;
  // The earlier player wins ties, so the new player needs a strictly larger value.
  assign cur_wins   = rd_data.value < cur_val;
  assign nxt        = level + LVL_W'(1);
  assign walk_on    = (nxt < n_eff) && pos_sh[1];
  assign start_walk = (n_eff != '0) && pos_in[0];
  assign in_take    = s_axis_tvalid && s_axis_tready;
  // A result is loaded into the output register on every match and on the
  // champion report, whenever that register is free or being drained.
  assign emit       = can_emit &&
                      ((state == S_WALK) || ((state == S_FINISH) && !(level < n_eff)));

  // A read is issued when a walk starts and again for each further level.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    unique case (state)
      S_IDLE: begin
        rd_en = in_take && start_walk;
      end
      S_WALK: begin
        rd_en   = can_emit && walk_on;
        rd_addr = nxt[ADDR_W-1:0];
      end
      S_FINISH: begin
        wr_en = level < n_eff;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[level[ADDR_W-1:0]] <= '{value: cur_val, index: cur_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      log_size      <= CFG_W'(4);
      arrival_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            // A configuration write restarts the bracket.
            log_size      <= cfg_data;
            arrival_count <= '0;
          end else if (in_take) begin
            pos     <= pos_in;
            pos_sh  <= pos_in;
            cur_val <= s_axis_tdata;
            cur_idx <= pos_in;
            level   <= '0;
            state   <= start_walk ? S_WALK : S_FINISH;
          end
        end
        S_WALK: begin
          if (can_emit) begin
            out_round <= ROUND_W'(nxt);
            // The result is the last of its run unless more matches or the
            // champion report follow.
            out_last  <= !walk_on && (nxt < n_eff);
            if (cur_wins) begin
              out_index <= rd_data.index;
            end else begin
              out_index <= cur_idx;
              cur_val   <= rd_data.value;
              cur_idx   <= rd_data.index;
            end
            level  <= nxt;
            pos_sh <= pos_sh >> 1;
            if (!walk_on) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (level < n_eff) begin
            arrival_count <= pos + INDEX_W'(1);
            state         <= S_IDLE;
          end else if (can_emit) begin
            out_index     <= cur_idx;
            out_round     <= ROUND_W'(n_eff);
            out_last      <= 1'b1;
            arrival_count <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Configuration is taken only between items, and it goes ahead of a player
  // offered in the same cycle, so a player always sees a settled log_size.
  assign cfg_ready     = (state == S_IDLE);
  assign s_axis_tready = (state == S_IDLE) && !cfg_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_W - INDEX_W - ROUND_W)'(0), out_round, out_index};
  assign m_axis_tlast  = out_last;

endmodule

/* hdl/kotr_checker.sv */
// Port-level checker for the knockout tournament block, bound to the top level.
`include "knockout_tournament_rounds_assert.svh"

module kotr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [kotr_pkg::OUT_W-1:0]   m_axis_tdata,
  input logic                         m_axis_tlast
);
  import kotr_pkg::*;

  `KOTR_ASSERT_NEXT(out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
  `KOTR_ASSERT_NOW(round_range, m_axis_tvalid, m_axis_tdata[INDEX_W +: ROUND_W] <= ROUND_W'(LOG_MAX), "round beyond store depth")
  `KOTR_ASSERT_NOW(pad_zero, m_axis_tvalid, m_axis_tdata[OUT_W-1:INDEX_W+ROUND_W] == '0, "tdata padding not zero")
  `KOTR_ASSERT_NEXT(busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken on consecutive cycles")

endmodule

bind knockout_tournament_rounds kotr_checker u_kotr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
